### sv/ttwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttwa_pkg
// types, constants and register indexes of the track table with aging
// ----------------------------------------------------------------------------
package ttwa_pkg;

    localparam int TRACKS_DEF = 64;

    typedef enum logic [1:0] {
        REQ_SIGHT = 2'd0,
        REQ_DECAY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_LOOK  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_FRESH  = 2'd0,
        CFG_STALE  = 2'd1,
        CFG_CDECAY = 2'd2,
        CFG_UGROW  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        target_id;
        logic [15:0]        observer_id;
        logic               spoofed;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        conf_in;
        logic [15:0]        uncert_in;
        logic [7:0]         class_in;
        logic [30:0]        round_now;
        logic [15:0]        clear_radius;
    } t_in;

    typedef struct packed {
        logic               found;
        logic               track_stale;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [15:0]        out_conf;
        logic [15:0]        out_uncert;
        logic [7:0]         out_class;
        logic [31:0]        out_sources;
        logic [30:0]        out_updated_round;
        logic [6:0]         live_count;
        logic               table_full;
    } t_out;

    // one stored track, without its valid bit
    typedef struct packed {
        logic [15:0]        target;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        conf;
        logic [15:0]        uncert;
        logic [7:0]         cls;
        logic [31:0]        sources;
        logic [30:0]        upd_round;
        logic [30:0]        dec_round;
        logic               stale;
    } t_entry;

    typedef struct packed {
        logic [15:0] fresh_len;
        logic [15:0] stale_len;
        logic [15:0] confidence_decay;
        logic [15:0] uncertainty_growth;
    } t_cfg;

    // aging outcome of one track
    typedef struct packed {
        logic   kill;
        t_entry ent;
    } t_age;

endpackage

### sv/track_table_with_aging_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_table_with_aging_unit
// track table keyed by target id, one memory of tracks with valid flops,
// sighting, decay, clear and lookup by a scan of the table
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | i_in_valid, o_in_stall, i_in_data    | request transactions
//  out     | o_out_valid, i_out_stall, o_out_data | one result each
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data      | register writes
//
// every item scans all TRACKS entries through the one memory read port,
// one entry a cycle; decay entries then go back through a two-stage pipe.
// the next transaction is taken at the edge where the result leaves.
// valid bits and live count clear at reset, the memory needs no clearing pass.
// a waiting result holds in the output register while the output stalls.
module track_table_with_aging_unit #(
    parameter int TRACKS = ttwa_pkg::TRACKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ttwa_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ttwa_pkg::t_out   o_out_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data
);

    localparam int AW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int CW = $clog2(TRACKS + 1);

    ttwa_pkg::t_entry  r_mem [TRACKS];
    logic [TRACKS-1:0] r_valid;
    logic [CW-1:0]     r_live;
    ttwa_pkg::t_cfg    r_cfg;
    ttwa_pkg::t_state  r_state, n_state;
    ttwa_pkg::t_in     r_req;
    logic [AW:0]       r_ra;      // read address, one extra bit for done
    logic              r_rv;      // read data valid
    logic [AW-1:0]     r_rslot;
    ttwa_pkg::t_entry  r_rd;
    logic              r_p1v, r_p2v;
    logic [AW-1:0]     r_p1slot, r_p2slot;
    logic              r_hit;
    logic [AW-1:0]     r_hslot;
    logic              r_free;
    logic [AW-1:0]     r_fslot;
    ttwa_pkg::t_entry  r_hent;
    logic              r_fin;
    logic              r_out_valid;
    ttwa_pkg::t_out    r_out;
    ttwa_pkg::t_out    n_out;

    ttwa_pkg::t_age    w_age;
    logic              w_accept;
    logic              w_scan_done;
    logic              w_rvalid;
    logic [16:0]       w_dx, w_dy;
    logic [31:0]       w_bit;
    ttwa_pkg::t_entry  w_new;
    logic              w_we;
    logic [AW-1:0]     w_wa;
    ttwa_pkg::t_entry  w_wd;
    logic              w_kill;
    logic              w_clr;
    logic              w_ins;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ttwa_pkg::ST_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fresh_len          <= 16'd3;
            r_cfg.stale_len          <= 16'd5;
            r_cfg.confidence_decay   <= 16'd6554;
            r_cfg.uncertainty_growth <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (ttwa_pkg::t_cfg_idx'(i_cfg_idx))
                ttwa_pkg::CFG_FRESH:  r_cfg.fresh_len          <= i_cfg_data;
                ttwa_pkg::CFG_STALE:  r_cfg.stale_len          <= i_cfg_data;
                ttwa_pkg::CFG_CDECAY: r_cfg.confidence_decay   <= i_cfg_data;
                ttwa_pkg::CFG_UGROW:  r_cfg.uncertainty_growth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan read address
    assign w_scan_done = (r_state == ttwa_pkg::ST_SCAN) && (r_ra == (AW+1)'(TRACKS))
                         && !r_rv && !r_p1v && !r_p2v;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttwa_pkg::ST_IDLE: if (w_accept) n_state = ttwa_pkg::ST_SCAN;
            ttwa_pkg::ST_SCAN: if (w_scan_done) n_state = ttwa_pkg::ST_DONE;
            ttwa_pkg::ST_DONE: n_state = ttwa_pkg::ST_IDLE;
            default:           n_state = ttwa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ttwa_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_req <= i_in_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra <= '0;
            r_rv <= 1'b0;
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
        end else begin
            if (w_accept) r_ra <= '0;
            else if (r_state == ttwa_pkg::ST_SCAN && r_ra != (AW+1)'(TRACKS))
                r_ra <= r_ra + 1'b1;
            r_rv  <= (r_state == ttwa_pkg::ST_SCAN) && (r_ra != (AW+1)'(TRACKS));
            r_p1v <= r_rv && r_req.req_type == ttwa_pkg::REQ_DECAY;
            r_p2v <= r_p1v;
        end
        r_rslot  <= r_ra[AW-1:0];
        r_p1slot <= r_rslot;
        r_p2slot <= r_p1slot;
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_ra[AW-1:0]];
    end

    assign w_rvalid = r_rv && r_valid[r_rslot];

    ttwa_age u_age (
        .i_clk (i_clk),
        .i_cfg (r_cfg),
        .i_ent (r_rd),
        .i_now (r_req.round_now),
        .o_age (w_age)
    );

    // search results of the scan
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_rv) begin
            if (w_rvalid && r_rd.target == r_req.target_id && !r_hit) begin
                r_hit   <= 1'b1;
                r_hslot <= r_rslot;
                r_hent  <= r_rd;
            end
            if (!r_valid[r_rslot] && !r_free) begin
                r_free  <= 1'b1;
                r_fslot <= r_rslot;
            end
        end
    end

    // clear distance
    always_comb begin
        w_dx = {r_rd.pos_x[15], r_rd.pos_x} - {r_req.pos_x[15], r_req.pos_x};
        w_dy = {r_rd.pos_y[15], r_rd.pos_y} - {r_req.pos_y[15], r_req.pos_y};
        if (w_dx[16]) w_dx = -w_dx;
        if (w_dy[16]) w_dy = -w_dy;
    end

    // sighting write at finish
    assign w_bit = r_req.spoofed ? 32'd0 : (32'd1 << r_req.observer_id[4:0]);
    always_comb begin
        w_new           = r_hent;
        w_new.target    = r_req.target_id;
        w_new.pos_x     = r_req.pos_x;
        w_new.pos_y     = r_req.pos_y;
        w_new.conf      = r_req.conf_in;
        w_new.uncert    = r_req.uncert_in;
        w_new.upd_round = r_req.round_now;
        w_new.dec_round = r_req.round_now;
        w_new.stale     = 1'b0;
        if (r_hit) begin
            w_new.sources = r_hent.sources | w_bit;
            if (r_req.class_in != 8'd0) w_new.cls = r_req.class_in;
        end else begin
            w_new.sources = w_bit;
            w_new.cls     = r_req.class_in;
        end
    end

    assign w_we = (r_p2v && r_valid[r_p2slot]) ||
                  (w_scan_done && r_req.req_type == ttwa_pkg::REQ_SIGHT && (r_hit || r_free));
    assign w_wa = r_p2v ? r_p2slot : (r_hit ? r_hslot : r_fslot);
    assign w_wd = r_p2v ? w_age.ent : w_new;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
    end

    // track removal by aging or by clear, insertion by a new sighting
    assign w_kill = r_p2v && r_valid[r_p2slot] && w_age.kill;
    assign w_clr  = w_rvalid && r_req.req_type == ttwa_pkg::REQ_CLEAR
                    && r_rd.sources == 32'd0
                    && w_dx <= {1'b0, r_req.clear_radius} && w_dy <= {1'b0, r_req.clear_radius};
    assign w_ins  = w_scan_done && r_req.req_type == ttwa_pkg::REQ_SIGHT && !r_hit && r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_kill) r_valid[r_p2slot] <= 1'b0;
            if (w_clr) r_valid[r_rslot] <= 1'b0;
            if (w_ins) r_valid[r_fslot] <= 1'b1;
        end
    end

    // at most one of the three events a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_live <= '0;
        else if (w_kill || w_clr) r_live <= r_live - CW'(1);
        else if (w_ins) r_live <= r_live + CW'(1);
    end

    // result
    always_comb begin
        n_out = '0;
        n_out.live_count = 7'(r_live);
        if (r_req.req_type == ttwa_pkg::REQ_SIGHT) begin
            n_out.found      = r_hit;
            n_out.table_full = !r_hit && !r_free;
        end else if (r_req.req_type == ttwa_pkg::REQ_LOOK && r_hit) begin
            n_out.found             = 1'b1;
            n_out.track_stale       = r_hent.stale;
            n_out.out_x             = r_hent.pos_x;
            n_out.out_y             = r_hent.pos_y;
            n_out.out_conf          = r_hent.conf;
            n_out.out_uncert        = r_hent.uncert;
            n_out.out_class         = r_hent.cls;
            n_out.out_sources       = r_hent.sources;
            n_out.out_updated_round = r_hent.upd_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_fin <= w_scan_done;
            if (r_fin) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
        if (r_fin) r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_out_only_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_fin)) else $error("result without scan");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ttwa_pkg::ST_IDLE |-> o_in_stall) else $error("accept while busy");
    a_pipe_only_decay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2v |-> r_req.req_type == ttwa_pkg::REQ_DECAY) else $error("aging on non decay");
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == CW'($countones(r_valid))) else $error("live count out of step");
`endif

endmodule

### sv/ttwa_age.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttwa_age
// two-stage aging of one track: span computation, then decay and growth
// ----------------------------------------------------------------------------
module ttwa_age (
    input  logic              i_clk,
    input  ttwa_pkg::t_cfg    i_cfg,
    input  ttwa_pkg::t_entry  i_ent,
    input  logic [30:0]       i_now,
    output ttwa_pkg::t_age    o_age
);

    logic signed [33:0] w_age;
    logic signed [33:0] w_prev;
    logic signed [33:0] w_s0;
    logic signed [33:0] w_s1;
    logic signed [33:0] w_lo;
    logic signed [33:0] w_hi;
    logic signed [33:0] w_k;

    // stage one registers
    ttwa_pkg::t_entry   r_ent;
    logic               r_kill;
    logic               r_stale;
    logic [16:0]        r_k;
    logic [30:0]        r_now;

    logic [32:0]        w_cdec;
    logic [32:0]        w_ugrow;
    logic [33:0]        w_u;
    ttwa_pkg::t_age     n_age;

    always_comb begin
        w_age  = $signed({3'b0, i_now}) - $signed({3'b0, i_ent.upd_round});
        w_prev = (i_now < i_ent.dec_round) ? w_age :
                 $signed({3'b0, i_ent.dec_round}) - $signed({3'b0, i_ent.upd_round});
        w_s0   = $signed({18'b0, i_cfg.fresh_len});
        w_s1   = w_s0 + $signed({18'b0, i_cfg.stale_len});
        w_hi   = (w_age < w_s1) ? w_age : w_s1;
        w_lo   = (w_prev > w_s0) ? w_prev : w_s0;
        w_k    = w_hi - w_lo;
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= i_ent;
        r_now   <= i_now;
        r_kill  <= w_age > w_s1;
        r_stale <= w_age > w_s0;
        // span is at most the stale length, which fits 17 bits
        r_k     <= (w_age > w_s0 && w_k > 0) ? w_k[16:0] : 17'd0;
    end

    always_comb begin
        w_cdec  = r_k * i_cfg.confidence_decay;
        w_ugrow = r_k * i_cfg.uncertainty_growth;
        w_u     = {18'b0, r_ent.uncert} + {1'b0, w_ugrow};
        n_age          = '0;
        n_age.kill     = r_kill;
        n_age.ent      = r_ent;
        n_age.ent.stale     = r_stale;
        n_age.ent.dec_round = r_now;
        if (r_stale && r_k != 17'd0) begin
            n_age.ent.conf   = (w_cdec >= {17'b0, r_ent.conf}) ? 16'd0 :
                               (r_ent.conf - w_cdec[15:0]);
            n_age.ent.uncert = (w_u > 34'hFFFF) ? 16'hFFFF : w_u[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_age <= n_age;
    end

endmodule
